>>> hdl/hop_limited_shortest_path_macros.svh
// assertion macros shared by the hop-limited shortest path block
`ifndef HOP_LIMITED_SHORTEST_PATH_MACROS_SVH
`define HOP_LIMITED_SHORTEST_PATH_MACROS_SVH

// property that must hold at every clock edge out of reset
`define HLSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HLSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define HLSP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/hlsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsp_pkg
// Types, codes and constants of the hop-limited shortest path block.
// ----------------------------------------------------------------------------
package hlsp_pkg;

	localparam int NODE_W   = 6;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W   = 24;
	localparam int NCNT_W   = 7;
	localparam int ROUND_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [DIST_W-1:0] DIST_UNREACH = 24'hFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_SAT_MAX = 24'hFF_FFFE;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUND_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_NODE   = 2'd3;

	localparam logic [NCNT_W-1:0]  NODE_COUNT_RST  = 7'd64;
	localparam logic [ROUND_W-1:0] ROUND_LIMIT_RST = 8'd63;

	typedef struct packed {
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   to_node;
		logic [WEIGHT_W-1:0] weight;
		logic                last_edge;
	} edge_item_t;

	typedef struct packed {
		logic              reachable;
		logic [DIST_W-1:0] distance;
	} result_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   to_node;
		logic [WEIGHT_W-1:0] weight;
	} edge_entry_t;

	localparam int EDGE_ENTRY_W = $bits(edge_entry_t);

	// relax unit operands and result
	typedef struct packed {
		logic                en;
		logic [DIST_W-1:0]   tail_dist;
		logic [DIST_W-1:0]   head_dist;
		logic [WEIGHT_W-1:0] weight;
	} relax_req_t;

	typedef struct packed {
		logic              upd;
		logic [DIST_W-1:0] value;
	} relax_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_COPY,
		ST_EADDR,
		ST_TADDR,
		ST_RELAX,
		ST_RES_RD,
		ST_RES
	} state_t;

endpackage

>>> hdl/hlsp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsp_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface hlsp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/hlsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hlsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/hlsp_relax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsp_relax
// Shared relaxation unit: saturating add of tail distance and weight,
// compared against the head distance.
// ----------------------------------------------------------------------------
module hlsp_relax (
	input  hlsp_pkg::relax_req_t req,
	output hlsp_pkg::relax_rsp_t rsp
);
	import hlsp_pkg::*;

	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] cand;

	assign sum  = {1'b0, req.tail_dist} + (DIST_W + 1)'(req.weight);
	// keep the sum clear of the unreachable code
	assign cand = (sum > {1'b0, DIST_SAT_MAX}) ? DIST_SAT_MAX : sum[DIST_W-1:0];

	assign rsp.value = cand;
	assign rsp.upd   = req.en && (req.tail_dist != DIST_UNREACH) && (cand < req.head_dist);
endmodule

>>> hdl/hop_limited_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_limited_shortest_path
// Edge loader and hop-limited Bellman-Ford sequencer around one relax unit.
// ----------------------------------------------------------------------------
// Edges are taken one item per cycle into the edge store; the item with
// last_edge set is stored too and then starts the solve, during which edges
// is not ready. Items past the store depth are not stored. The solve runs
// round_limit rounds: each round first copies the active entries of the
// distance table into the previous-round table one entry per cycle, then
// relaxes every stored edge in three steps (edge store read, table reads,
// relax and write back) through the single shared add-compare unit. The
// result item then waits in an output register until taken; edge loading
// resumes as soon as it is loaded.
// Distance table entries not yet written in a solve read as unreachable
// through per-entry valid bits that clear in the first solve cycle.
// ----------------------------------------------------------------------------
`include "hop_limited_shortest_path_macros.svh"

module hop_limited_shortest_path #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hlsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hlsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	hlsp_stream_if.sink                        edges,
	hlsp_stream_if.source                      results
);
	import hlsp_pkg::*;

	// only nodes below 64 can be named, so the tables stop there
	localparam int TD     = (MAX_NODES < 64) ? MAX_NODES : 64;
	localparam int TAW    = $clog2(TD);
	localparam int TDEPTH = 1 << TAW;
	localparam int NCAP   = (MAX_NODES < 127) ? MAX_NODES : 127;
	localparam logic [NCNT_W-1:0] NCAP_W = NCNT_W'(NCAP);
	localparam logic [NCNT_W-1:0] TD_W   = NCNT_W'(TD);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam logic [ECW-1:0] EMAX_W = ECW'(MAX_EDGES);

	// configuration
	logic [NCNT_W-1:0]  node_count_q;
	logic [ROUND_W-1:0] round_limit_q;
	logic [NODE_W-1:0]  source_node_q;
	logic [NODE_W-1:0]  dest_node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= NODE_COUNT_RST;
			round_limit_q <= ROUND_LIMIT_RST;
			source_node_q <= '0;
			dest_node_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_COUNT:  node_count_q  <= cfg_data[NCNT_W-1:0];
				CFG_ROUND_LIMIT: round_limit_q <= cfg_data[ROUND_W-1:0];
				CFG_SOURCE_NODE: source_node_q <= cfg_data[NODE_W-1:0];
				CFG_DEST_NODE:   dest_node_q   <= cfg_data[NODE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [NCNT_W-1:0] n_act;
	logic [NCNT_W-1:0] copy_n;
	logic              src_ok;
	logic              dest_ok;

	always_comb begin
		if (node_count_q == '0) begin
			n_act = NCNT_W'(1);
		end else if (node_count_q > NCAP_W) begin
			n_act = NCAP_W;
		end else begin
			n_act = node_count_q;
		end
	end

	assign copy_n  = (n_act > TD_W) ? TD_W : n_act;
	assign src_ok  = {1'b0, source_node_q} < n_act;
	assign dest_ok = {1'b0, dest_node_q} < n_act;

	// sequencer registers
	state_t            state_q, state_d;
	logic [ECW-1:0]    edge_cnt_q;
	logic [ECW-1:0]    e_q;
	logic [ROUND_W-1:0] rnd_q;
	logic [NCNT_W-1:0] cnt_q;
	logic              cp_pend_q;
	logic [TAW-1:0]    cp_addr_q;
	logic [NODE_W-1:0] head_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic              edge_ok_q;
	logic [TDEPTH-1:0] vld_q;
	logic              cur_rvld_q;
	logic              res_vld_q;
	result_item_t      res_q;

	// memories
	edge_entry_t       edge_wdata;
	logic [EDGE_ENTRY_W-1:0] edge_rdata_raw;
	edge_entry_t       edge_rdata;
	logic              edge_we;
	logic [EAW-1:0]    edge_raddr;

	logic              cur_we;
	logic [TAW-1:0]    cur_waddr;
	logic [DIST_W-1:0] cur_wdata;
	logic [TAW-1:0]    cur_raddr;
	logic [DIST_W-1:0] cur_rdata;
	logic [DIST_W-1:0] cur_eff;

	logic [TAW-1:0]    prev_raddr;
	logic [DIST_W-1:0] prev_rdata;

	relax_req_t        rlx_req;
	relax_rsp_t        rlx_rsp;

	logic              in_acc;
	logic              round_end;
	logic              last_round;

	assign edges.ready   = (state_q == ST_IDLE);
	assign in_acc        = edges.valid && edges.ready;
	assign edge_we       = in_acc && (edge_cnt_q < EMAX_W);
	assign edge_wdata    = '{from_node: edges.data.from_node, to_node: edges.data.to_node,
	                         weight: edges.data.weight};
	assign edge_raddr    = e_q[EAW-1:0];
	assign edge_rdata    = edge_rdata_raw;
	assign cur_eff       = cur_rvld_q ? cur_rdata : DIST_UNREACH;
	assign round_end     = (state_q == ST_EADDR) && (e_q >= edge_cnt_q);
	assign last_round    = ({1'b0, rnd_q} + 9'd1) == {1'b0, round_limit_q};

	hlsp_ram #(.WIDTH(EDGE_ENTRY_W), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_cnt_q[EAW-1:0]),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata_raw)
	);

	hlsp_ram #(.WIDTH(DIST_W), .DEPTH(TDEPTH), .AW(TAW)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	hlsp_ram #(.WIDTH(DIST_W), .DEPTH(TDEPTH), .AW(TAW)) u_prev_ram (
		.clk   (clk),
		.we    (cp_pend_q),
		.waddr (cp_addr_q),
		.wdata (cur_eff),
		.raddr (prev_raddr),
		.rdata (prev_rdata)
	);

	assign rlx_req = '{en: edge_ok_q, tail_dist: prev_rdata, head_dist: cur_eff,
	                   weight: weight_q};

	hlsp_relax u_relax (
		.req (rlx_req),
		.rsp (rlx_rsp)
	);

	// next state and memory control
	always_comb begin
		state_d    = state_q;
		cur_we     = 1'b0;
		cur_waddr  = head_q[TAW-1:0];
		cur_wdata  = rlx_rsp.value;
		cur_raddr  = '0;
		prev_raddr = edge_rdata.from_node[TAW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && edges.data.last_edge) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cur_we    = src_ok;
				cur_waddr = source_node_q[TAW-1:0];
				cur_wdata = '0;
				state_d   = (round_limit_q == '0) ? ST_RES_RD : ST_COPY;
			end
			ST_COPY: begin
				cur_raddr = cnt_q[TAW-1:0];
				if (cnt_q >= copy_n) begin
					state_d = ST_EADDR;
				end
			end
			ST_EADDR: begin
				if (round_end) begin
					state_d = last_round ? ST_RES_RD : ST_COPY;
				end else begin
					state_d = ST_TADDR;
				end
			end
			ST_TADDR: begin
				cur_raddr = edge_rdata.to_node[TAW-1:0];
				state_d   = ST_RELAX;
			end
			ST_RELAX: begin
				cur_we  = rlx_rsp.upd;
				state_d = ST_EADDR;
			end
			ST_RES_RD: begin
				cur_raddr = dest_node_q[TAW-1:0];
				state_d   = ST_RES;
			end
			ST_RES: begin
				cur_raddr = dest_node_q[TAW-1:0];
				if (!res_vld_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
			e_q        <= '0;
			rnd_q      <= '0;
			cnt_q      <= '0;
			cp_pend_q  <= 1'b0;
			vld_q      <= '0;
			cur_rvld_q <= 1'b0;
			edge_ok_q  <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			cur_rvld_q <= vld_q[cur_raddr];
			cp_pend_q  <= (state_q == ST_COPY) && (cnt_q < copy_n);
			if (edge_we) begin
				edge_cnt_q <= edge_cnt_q + ECW'(1);
			end
			if (results.ready && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					// only the source starts out written
					vld_q <= src_ok ? (TDEPTH'(1) << source_node_q[TAW-1:0]) : '0;
					rnd_q <= '0;
					cnt_q <= '0;
				end
				ST_COPY: begin
					if (cnt_q < copy_n) begin
						cnt_q <= cnt_q + NCNT_W'(1);
					end else begin
						e_q <= '0;
					end
				end
				ST_EADDR: begin
					if (round_end) begin
						rnd_q <= rnd_q + ROUND_W'(1);
						cnt_q <= '0;
					end
				end
				ST_TADDR: begin
					edge_ok_q <= ({1'b0, edge_rdata.from_node} < n_act) &&
					             ({1'b0, edge_rdata.to_node} < n_act);
				end
				ST_RELAX: begin
					if (rlx_rsp.upd) begin
						vld_q[head_q[TAW-1:0]] <= 1'b1;
					end
					e_q <= e_q + ECW'(1);
				end
				ST_RES: begin
					if (!res_vld_q) begin
						res_vld_q  <= 1'b1;
						edge_cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_TADDR) begin
			head_q   <= edge_rdata.to_node;
			weight_q <= edge_rdata.weight;
		end
		if (state_q == ST_COPY) begin
			cp_addr_q <= cnt_q[TAW-1:0];
		end
		if ((state_q == ST_RES) && !res_vld_q) begin
			if (!dest_ok || (cur_eff == DIST_UNREACH)) begin
				res_q <= '{reachable: 1'b0, distance: '0};
			end else begin
				res_q <= '{reachable: 1'b1, distance: cur_eff};
			end
		end
	end

	assign results.valid = res_vld_q;
	assign results.data  = res_q;

	`HLSP_ASSERT_ALWAYS(a_edge_cnt_bound, edge_cnt_q <= EMAX_W, "edge count beyond store depth")
	`HLSP_ASSERT_NEXT(a_last_starts, in_acc && edges.data.last_edge, state_q == ST_INIT, "last edge did not start solve")
	`HLSP_ASSERT_SAME(a_no_sentinel_wr, cur_we, cur_wdata != DIST_UNREACH, "unreachable code written as distance")
	`HLSP_ASSERT_SAME(a_result_src, $rose(res_vld_q), $past(state_q) == ST_RES, "result raised outside result state")

endmodule
